// File: sv/spt_pkg.sv
// Shared codes, widths and constants for the sorted priority table.
`timescale 1ns / 1ps

package spt_pkg;

    localparam int FUNC_W   = 2;
    localparam int TICKET_W = 16;
    localparam int SEV_W    = 3;
    localparam int AGE_W    = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_EDIT   = 2'd2,
        FUNC_REMOVE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADSEV   = 3'd4
    } t_status;

    localparam logic [SEV_W-1:0] SEV_MIN = 3'd1;
    localparam logic [SEV_W-1:0] SEV_MAX = 3'd4;

endpackage

// File: sv/spt_if.sv
// Request and response channel interfaces of the sorted priority table.
`timescale 1ns / 1ps

interface spt_req_if;
    logic                         valid;
    logic                         ready;
    logic [spt_pkg::FUNC_W-1:0]   func;
    logic [spt_pkg::TICKET_W-1:0] ticket;
    logic [spt_pkg::SEV_W-1:0]    severity;
    logic [spt_pkg::AGE_W-1:0]    age;

    modport source (output valid, func, ticket, severity, age, input ready);
    modport sink   (input valid, func, ticket, severity, age, output ready);
endinterface

interface spt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spt_pkg::STATUS_W-1:0] status;
    logic [spt_pkg::SEV_W-1:0]    found_severity;
    logic [spt_pkg::AGE_W-1:0]    found_age;
    logic [spt_pkg::POS_W-1:0]    position;
    logic [spt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, status, found_severity, found_age, position, entry_count,
                    input ready);
    modport sink   (input valid, status, found_severity, found_age, position, entry_count,
                    output ready);
endinterface

// File: sv/sorted_priority_table.sv
// Top level of the sorted priority table: sequencer, shared compare unit, entry RAM.
`timescale 1ns / 1ps

// Usage:
//   i_req carries one request per beat (func, ticket, severity, age); o_rsp
//   returns exactly one response beat per request, in order.
//   Entries live in a RAM kept sorted by severity, then ticket. Every
//   request first scans the n stored entries through one compare unit, one
//   entry per cycle, pipelined behind the RAM's registered read.
//   Insert and remove then shift the entries behind the slot over the same
//   RAM port pair, one entry per cycle: m = n - slot entries for an insert,
//   m = n - 1 - slot for a remove, n = entries held. An edit rewrites the
//   found entry in place; lookups and errors shift nothing. One request at
//   a time: i_req.ready is high only while the sequencer is idle.
//   The response sits in an output register; a new request is taken while
//   it waits, but the next response holds until the receiver takes it.
//   Reset empties the table (count to zero) and drops any pending response;
//   RAM contents are not cleared, as only slots below the count are read.
module sorted_priority_table #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spt_req_if.sink    i_req,
    spt_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + spt_pkg::SEV_W + spt_pkg::AGE_W;
    localparam int AGE_LO = 0;
    localparam int SEV_LO = spt_pkg::AGE_W;
    localparam int KEY_LO = spt_pkg::AGE_W + spt_pkg::SEV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic [spt_pkg::FUNC_W-1:0]      r_func;
    logic [KEY_BITS-1:0]             r_key;
    logic [spt_pkg::SEV_W-1:0]       r_sev;
    logic [spt_pkg::AGE_W-1:0]       r_age;

    logic [CW-1:0]                   r_rd_idx;
    logic                            r_chk_valid;
    logic [IW-1:0]                   r_chk_idx;
    logic                            r_hit;
    logic [IW-1:0]                   r_hit_idx;
    logic [spt_pkg::SEV_W-1:0]       r_hit_sev;
    logic [spt_pkg::AGE_W-1:0]       r_hit_age;
    logic                            r_at_found;
    logic [CW-1:0]                   r_at;

    logic [CW-1:0]                   r_moves;
    logic [IW-1:0]                   r_src;
    logic                            r_up;
    logic                            r_wb_valid;
    logic [IW-1:0]                   r_wb_addr;
    logic [IW-1:0]                   r_wr_addr;
    logic [EW-1:0]                   r_wr_data;

    logic [spt_pkg::STATUS_W-1:0]    r_status;
    logic [spt_pkg::SEV_W-1:0]       r_fsev;
    logic [spt_pkg::AGE_W-1:0]       r_fage;
    logic [IW-1:0]                   r_pos;

    logic                            r_out_valid;
    logic [spt_pkg::STATUS_W-1:0]    r_out_status;
    logic [spt_pkg::SEV_W-1:0]       r_out_fsev;
    logic [spt_pkg::AGE_W-1:0]       r_out_fage;
    logic [spt_pkg::POS_W-1:0]       r_out_pos;
    logic [spt_pkg::COUNT_W-1:0]     r_out_count;

    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    logic [EW-1:0]                   ram_wdata;
    logic [IW-1:0]                   ram_raddr;
    logic [EW-1:0]                   ram_rdata;

    logic [KEY_BITS-1:0]             e_key;
    logic [spt_pkg::SEV_W-1:0]       e_sev;
    logic [spt_pkg::AGE_W-1:0]       e_age;
    logic                            key_eq;
    logic                            new_before;
    logic                            sev_bad;

    // shared compare unit
    assign e_key      = ram_rdata[KEY_LO +: KEY_BITS];
    assign e_sev      = ram_rdata[SEV_LO +: spt_pkg::SEV_W];
    assign e_age      = ram_rdata[AGE_LO +: spt_pkg::AGE_W];
    assign key_eq     = (e_key == r_key);
    assign new_before = (r_sev < e_sev) || ((r_sev == e_sev) && (r_key < e_key));
    assign sev_bad    = (r_sev < spt_pkg::SEV_MIN) || (r_sev > spt_pkg::SEV_MAX);

    always_comb begin
        ram_raddr = (r_state == S_SHIFT) ? r_src : r_rd_idx[IW-1:0];
        ram_we    = ((r_state == S_SHIFT) && r_wb_valid) || (r_state == S_WRITE);
        ram_waddr = (r_state == S_WRITE) ? r_wr_addr : r_wb_addr;
        ram_wdata = (r_state == S_WRITE) ? r_wr_data : ram_rdata;
    end

    spt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_spt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func      <= i_req.func;
                        r_key       <= KEY_BITS'(i_req.ticket);
                        r_sev       <= i_req.severity;
                        r_age       <= i_req.age;
                        r_rd_idx    <= '0;
                        r_chk_valid <= 1'b0;
                        r_hit       <= 1'b0;
                        r_at_found  <= 1'b0;
                        r_at        <= r_count;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_idx != r_count) begin
                        r_rd_idx    <= r_rd_idx + CW'(1);
                        r_chk_valid <= 1'b1;
                        r_chk_idx   <= r_rd_idx[IW-1:0];
                    end else begin
                        r_chk_valid <= 1'b0;
                    end
                    if (r_chk_valid) begin
                        if (!r_hit && key_eq) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                            r_hit_sev <= e_sev;
                            r_hit_age <= e_age;
                        end
                        if (!r_at_found && new_before) begin
                            r_at_found <= 1'b1;
                            r_at       <= CW'(r_chk_idx);
                        end
                    end
                    if ((r_rd_idx == r_count) && !r_chk_valid) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_status   <= spt_pkg::ST_OK;
                    r_fsev     <= '0;
                    r_fage     <= '0;
                    r_pos      <= '0;
                    r_wb_valid <= 1'b0;
                    r_state    <= S_DONE;
                    if (r_func == spt_pkg::FUNC_INSERT) begin
                        if (r_hit) begin
                            r_status <= spt_pkg::ST_DUP;
                            r_fsev   <= r_hit_sev;
                            r_fage   <= r_hit_age;
                            r_pos    <= r_hit_idx;
                        end else if (sev_bad) begin
                            r_status <= spt_pkg::ST_BADSEV;
                        end else if (r_count == CW'(CAPACITY)) begin
                            r_status <= spt_pkg::ST_FULL;
                        end else begin
                            r_pos     <= r_at[IW-1:0];
                            r_moves   <= r_count - r_at;
                            r_src     <= IW'(r_count - CW'(1));
                            r_up      <= 1'b0;
                            r_wr_addr <= r_at[IW-1:0];
                            r_wr_data <= {r_key, r_sev, r_age};
                            r_count   <= r_count + CW'(1);
                            r_state   <= S_SHIFT;
                        end
                    end else if (!r_hit) begin
                        r_status <= spt_pkg::ST_NOTFOUND;
                    end else begin
                        r_fsev <= r_hit_sev;
                        r_fage <= (r_func == spt_pkg::FUNC_EDIT) ? r_age : r_hit_age;
                        r_pos  <= r_hit_idx;
                        if (r_func == spt_pkg::FUNC_EDIT) begin
                            r_wr_addr <= r_hit_idx;
                            r_wr_data <= {r_key, r_hit_sev, r_age};
                            r_state   <= S_WRITE;
                        end else if (r_func == spt_pkg::FUNC_REMOVE) begin
                            r_moves <= r_count - CW'(1) - CW'(r_hit_idx);
                            r_src   <= r_hit_idx + IW'(1);
                            r_up    <= 1'b1;
                            r_count <= r_count - CW'(1);
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_moves != '0) begin
                        r_moves    <= r_moves - CW'(1);
                        r_wb_valid <= 1'b1;
                        r_wb_addr  <= r_up ? (r_src - IW'(1)) : (r_src + IW'(1));
                        r_src      <= r_up ? (r_src + IW'(1)) : (r_src - IW'(1));
                    end else begin
                        r_wb_valid <= 1'b0;
                        if (!r_wb_valid) begin
                            r_state <= r_up ? S_DONE : S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_fsev   <= r_fsev;
                        r_out_fage   <= r_fage;
                        r_out_pos    <= spt_pkg::POS_W'(r_pos);
                        r_out_count  <= spt_pkg::COUNT_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.found_severity = r_out_fsev;
    assign o_rsp.found_age      = r_out_fage;
    assign o_rsp.position       = r_out_pos;
    assign o_rsp.entry_count    = r_out_count;

endmodule

// File: sv/spt_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module spt_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/spt_checker.sv
// Port-level assertions for the sorted priority table, bound to the top level.
`timescale 1ns / 1ps

module spt_checker #(
    parameter int CAPACITY = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [spt_pkg::STATUS_W-1:0] i_status,
    input logic [spt_pkg::SEV_W-1:0]    i_found_severity,
    input logic [spt_pkg::AGE_W-1:0]    i_found_age,
    input logic [spt_pkg::POS_W-1:0]    i_position,
    input logic [spt_pkg::COUNT_W-1:0]  i_entry_count
);

    // one request in flight: busy right after a request beat
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while a request was in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_entry_count) <= CAPACITY))
        else $error("entry count above capacity");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == spt_pkg::ST_NOTFOUND)) |->
        ((i_found_severity == '0) && (i_found_age == '0) && (i_position == '0)))
        else $error("not-found response carries entry data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_status) && $stable(i_found_severity) &&
         $stable(i_found_age) && $stable(i_position) && $stable(i_entry_count)))
        else $error("stalled response beat changed");

endmodule

bind sorted_priority_table spt_checker #(
    .CAPACITY (CAPACITY)
) u_spt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_found_severity (o_rsp.found_severity),
    .i_found_age      (o_rsp.found_age),
    .i_position       (o_rsp.position),
    .i_entry_count    (o_rsp.entry_count)
);
